// ===== hdl/block_ring_pointer_tracker_assert.svh =====
// Assertion macros shared by the ring pointer tracker RTL.
`ifndef BLOCK_RING_POINTER_TRACKER_ASSERT_SVH
`define BLOCK_RING_POINTER_TRACKER_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define BRPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked only outside reset.
`define BRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/brpt_pkg.sv =====
// Package with widths, codes and types of the block ring pointer tracker.
package brpt_pkg;

  localparam int BUF_AW       = 15;
  localparam int BLK_AW       = 10;
  localparam int IDX_W        = BUF_AW - BLK_AW;
  localparam int DATA_W       = 8;
  localparam int DELAY_W      = 14;
  localparam int SAMPLE_SHIFT = 2;
  localparam int LIM_W        = DELAY_W + SAMPLE_SHIFT;
  localparam int SAMPLE_BYTES = 1 << SAMPLE_SHIFT;
  localparam int BUF_BYTES    = 1 << BUF_AW;

  localparam logic [BUF_AW-1:0] CAP_BYTES = BUF_AW'(BUF_BYTES - SAMPLE_BYTES);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DONE  = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  civ_index;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BUF_AW-1:0] wp;
    logic [BUF_AW-1:0] rp;
  } ptr_t;

  // Declared from the highest bit down so that accepted sits at bit 0.
  typedef struct packed {
    logic              drained_enough;
    logic [BUF_AW-1:0] space_bytes;
    logic [BUF_AW-1:0] buffered_bytes;
    logic [IDX_W-1:0]  lvi_index;
    logic              lvi_valid;
    logic [DATA_W-1:0] mem_byte;
    logic [BUF_AW-1:0] mem_addr;
    logic              accepted;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hdl/brpt_step.sv =====
// Next-pointer and result logic for one request of the ring pointer tracker.
module brpt_step (
  input  brpt_pkg::item_t                  item_i,
  input  brpt_pkg::ptr_t                   ptr_i,
  input  logic [brpt_pkg::DELAY_W-1:0]     delay_i,
  output brpt_pkg::ptr_t                   ptr_o,
  output brpt_pkg::result_t                res_o
);
  import brpt_pkg::*;

  logic [BUF_AW-1:0] occ_cur;
  logic [BUF_AW-1:0] occ_new;
  logic [LIM_W-1:0]  lim;
  logic              can_write;

  assign occ_cur   = ptr_i.wp - ptr_i.rp;
  assign can_write = occ_cur < CAP_BYTES;
  assign lim       = {delay_i, {SAMPLE_SHIFT{1'b0}}};

  always_comb begin
    ptr_o = ptr_i;
    res_o = '0;
    unique case (item_i.op)
      OP_WRITE: begin
        if (can_write) begin
          res_o.accepted = 1'b1;
          res_o.mem_addr = ptr_i.wp;
          res_o.mem_byte = item_i.data_byte;
          ptr_o.wp       = ptr_i.wp + BUF_AW'(1);
          if (&ptr_i.wp[BLK_AW-1:0]) begin
            res_o.lvi_valid = 1'b1;
            res_o.lvi_index = ptr_i.wp[BUF_AW-1:BLK_AW];
          end
        end
      end
      OP_DONE: begin
        ptr_o.rp = {item_i.civ_index, {BLK_AW{1'b0}}};
      end
      default: begin
        ptr_o = ptr_i;
      end
    endcase
    occ_new              = ptr_o.wp - ptr_o.rp;
    res_o.buffered_bytes = occ_new;
    res_o.space_bytes    = (occ_new >= CAP_BYTES) ? '0 : CAP_BYTES - occ_new;
    res_o.drained_enough = (delay_i == '0) || ({1'b0, occ_new} <= lim);
  end

endmodule

// ===== hdl/block_ring_pointer_tracker.sv =====
// Top level of the block ring pointer tracker for a descriptor-driven audio ring.
//
// Input stream: each request either offers one byte for the ring (tuser low) or reports
// that the DMA engine now serves the descriptor given in civ_index (tuser high).
// Output stream: exactly one result per request, in order. It carries whether the byte
// was stored and its ring address, a last-valid-index update when the writer leaves a
// block, and the occupancy, free space and drained flag after the request.
// Configuration: cfg_data sets the target delay in samples; it is always ready. The user
// writes it between requests while the stream is quiet; the block does not enforce this.
// Pipeline: a request taken into the input register moves its result into the result
// register when it advances. Throughput: one request per cycle while the output is not
// stalled, set by the single input register and the pointer update loop.
// Stall: the result register holds its value while out_tready is low; the input
// register keeps one more request, after which in_tready drops until the output drains.
// Reset: rst_n clears both ring pointers, the delay and all valid flags.
`include "block_ring_pointer_tracker_assert.svh"

module block_ring_pointer_tracker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_tdata: data_byte[7:0], civ_index[12:8], zero padding.
  input  logic [brpt_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: op[0].
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: accepted, mem_addr, mem_byte, lvi_valid, lvi_index, buffered_bytes,
  // space_bytes, drained_enough, zero padding.
  output logic [brpt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [brpt_pkg::DELAY_W-1:0]         cfg_data
);
  import brpt_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           out_res_r;
  ptr_t              ptr_r;
  ptr_t              ptr_nxt;
  logic [DELAY_W-1:0] delay_r;
  ptr_t              step_ptr;
  result_t           step_res;
  item_t             in_item;
  logic              in_fire;
  logic              s1_adv;

  assign in_item.op        = in_tuser;
  assign in_item.civ_index = in_tdata[DATA_W+IDX_W-1:DATA_W];
  assign in_item.data_byte = in_tdata[DATA_W-1:0];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  brpt_step u_step (
    .item_i  (s1_item_r),
    .ptr_i   (ptr_r),
    .delay_i (delay_r),
    .ptr_o   (step_ptr),
    .res_o   (step_res)
  );

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
    ptr_nxt       = s1_adv ? step_ptr : ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      delay_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        delay_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_res_r};

  `BRPT_ASSERT_NEXT(a_wp_step, clk, rst_n, s1_adv && step_res.accepted,
    ptr_r.wp == BUF_AW'($past(ptr_r.wp) + BUF_AW'(1)))
  `BRPT_ASSERT_NEXT(a_rp_jump, clk, rst_n, s1_adv && (s1_item_r.op == OP_DONE),
    ptr_r.rp == {$past(s1_item_r.civ_index), {BLK_AW{1'b0}}})
  `BRPT_ASSERT_SAME(a_lvi_edge, clk, rst_n, out_valid_r && out_res_r.lvi_valid,
    out_res_r.accepted && (&out_res_r.mem_addr[BLK_AW-1:0]))
  `BRPT_ASSERT_SAME(a_space_sum, clk, rst_n,
    out_valid_r && (out_res_r.space_bytes != '0),
    BUF_AW'(out_res_r.space_bytes + out_res_r.buffered_bytes) == CAP_BYTES)
  `BRPT_ASSERT_SAME(a_reject_clean, clk, rst_n, out_valid_r && !out_res_r.accepted,
    (out_res_r.mem_addr == '0) && (out_res_r.mem_byte == '0))

endmodule
